### design/ecc_pkg.sv
// types and constants of the elevator collective control block
package ecc_pkg;

    // car motion, also the encoding of the motion result field
    typedef enum logic [1:0] {
        MOT_DOWN = 2'd0,
        MOT_UP   = 2'd1,
        MOT_IDLE = 2'd2
    } t_motion;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_CAR  = 2'd0,
        KIND_HALL = 2'd1,
        KIND_TICK = 2'd2
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_AT_FLOOR = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic [1:0] CFG_LOWEST  = 2'd0;
    localparam logic [1:0] CFG_HIGHEST = 2'd1;

    // configuration reset values
    localparam logic [2:0] LOWEST_RST  = 3'd0;
    localparam logic [2:0] HIGHEST_RST = 3'd7;

endpackage

### design/elevator_collective_control_top.sv
// elevator collective control: one car, directional scan over call bitmaps
//
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_stall   i_in_kind, i_in_floor, i_in_hall_up
// out      out  o_out_valid / i_out_stall o_out_status, o_out_stopped,
//                                         o_out_car_floor, o_out_motion
// cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle while the output is not stalled; an accepted input beat is
// held in the input register, then its result loads into the result register
// the car state updates in the same cycle the result register loads, so the
// next item always sees the state its predecessor left
// i_rst_n is synchronous, active low: car at floor 0, idle, no calls, limits 0..7
// a stall on the output holds the result register; the input stalls only when
// both registers are full and the output is stalled
module elevator_collective_control_top
    import ecc_pkg::*;
#(
    parameter int FLOORS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_in_kind,
    input  logic [2:0] i_in_floor,
    input  logic       i_in_hall_up,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_out_status,
    output logic       o_out_stopped,
    output logic [2:0] o_out_car_floor,
    output logic [1:0] o_out_motion,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [2:0] i_cfg_data
);

    // highest floor the car can reach given the bitmap size
    localparam int         TOP_CAP   = (FLOORS - 1 > 7) ? 7 : FLOORS - 1;
    localparam logic [2:0] TOP_CAP_F = 3'(TOP_CAP);

    // configuration
    logic [2:0] r_lowest;
    logic [2:0] r_highest;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_kind;
    logic [2:0] r_in_floor;
    logic       r_in_hall_up;

    // car state
    logic [2:0]        r_pos,  n_pos;
    t_motion           r_motion, n_motion;
    logic [FLOORS-1:0] r_up,   n_up;
    logic [FLOORS-1:0] r_down, n_down;
    logic [FLOORS-1:0] r_car,  n_car;

    // result register
    logic       r_out_valid;
    t_status    r_out_status, n_status;
    logic       r_out_stopped, n_stopped;
    logic [2:0] r_out_floor;
    t_motion    r_out_motion;

    // pipeline control
    logic w_adv;
    logic w_in_acc;

    // per-item combinational terms
    logic [FLOORS-1:0] w_call_bit;
    logic [FLOORS-1:0] w_pos_bit;
    logic [FLOORS-1:0] w_above;
    logic [FLOORS-1:0] w_below;
    logic [FLOORS-1:0] w_all;
    logic [FLOORS-1:0] w_ahead;
    logic [FLOORS-1:0] w_same;
    logic [FLOORS-1:0] w_opp;
    logic [2:0]        w_top;
    logic [2:0]        w_pos_nx;
    logic              w_going_up;
    logic              w_in_range;

    // handshake
    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= LOWEST_RST;
            r_highest <= HIGHEST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOWEST:  r_lowest  <= i_cfg_data;
                CFG_HIGHEST: r_highest <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_kind    <= i_in_kind;
            r_in_floor   <= i_in_floor;
            r_in_hall_up <= i_in_hall_up;
        end
    end

    // tick position: one floor in the direction of motion, clamped
    assign w_going_up = (r_motion == MOT_UP);
    assign w_top      = (r_highest > TOP_CAP_F) ? TOP_CAP_F : r_highest;
    always_comb begin
        w_pos_nx = r_pos;
        if (w_going_up) begin
            if (r_pos < w_top) w_pos_nx = r_pos + 3'd1;
        end else begin
            if (r_pos > r_lowest) w_pos_nx = r_pos - 3'd1;
        end
    end

    // floor masks
    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            w_call_bit[i] = (32'(r_in_floor) == i);
            w_pos_bit[i]  = (32'(w_pos_nx) == i);
            w_above[i]    = (i > 32'(w_pos_nx));
            w_below[i]    = (i < 32'(w_pos_nx));
        end
    end

    assign w_all      = r_up | r_down | r_car;
    assign w_ahead    = w_all & (w_going_up ? w_above : w_below);
    assign w_same     = w_going_up ? r_up : r_down;
    assign w_opp      = w_going_up ? r_down : r_up;
    assign w_in_range = (r_in_floor >= r_lowest) && (r_in_floor <= r_highest)
                        && (32'(r_in_floor) < FLOORS);

    // next car state and result
    always_comb begin
        n_pos     = r_pos;
        n_motion  = r_motion;
        n_up      = r_up;
        n_down    = r_down;
        n_car     = r_car;
        n_status  = ST_OK;
        n_stopped = 1'b0;
        case (r_in_kind) inside
            KIND_CAR, KIND_HALL: begin
                if (!w_in_range) begin
                    n_status = ST_RANGE;
                end else if (r_in_floor == r_pos) begin
                    n_status = ST_AT_FLOOR;
                end else begin
                    if (r_in_kind == KIND_CAR) n_car = r_car | w_call_bit;
                    else if (r_in_hall_up)     n_up = r_up | w_call_bit;
                    else                       n_down = r_down | w_call_bit;
                    if (r_motion == MOT_IDLE) begin
                        n_motion = (r_pos < r_in_floor) ? MOT_UP : MOT_DOWN;
                    end
                end
            end
            KIND_TICK: begin
                if (r_motion == MOT_UP || r_motion == MOT_DOWN) begin
                    n_pos = w_pos_nx;
                    // stop for car call or same-direction hall call
                    if (|((r_car | w_same) & w_pos_bit)) begin
                        n_stopped = 1'b1;
                        n_car     = r_car & ~w_pos_bit;
                        if (w_going_up) n_up = r_up & ~w_pos_bit;
                        else            n_down = r_down & ~w_pos_bit;
                    // opposite call served only with nothing ahead
                    end else if ((|(w_opp & w_pos_bit)) && !(|w_ahead)) begin
                        n_stopped = 1'b1;
                        if (w_going_up) n_down = r_down & ~w_pos_bit;
                        else            n_up = r_up & ~w_pos_bit;
                    end
                    if (!(|(n_up | n_down | n_car))) begin
                        n_motion = MOT_IDLE;
                    end else if (!(|w_ahead)) begin
                        n_motion = w_going_up ? MOT_DOWN : MOT_UP;
                    end
                end
            end
            default: ;
        endcase
    end

    // car state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 3'd0;
            r_motion <= MOT_IDLE;
            r_up     <= '0;
            r_down   <= '0;
            r_car    <= '0;
        end else if (w_adv) begin
            r_pos    <= n_pos;
            r_motion <= n_motion;
            r_up     <= n_up;
            r_down   <= n_down;
            r_car    <= n_car;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status  <= n_status;
            r_out_stopped <= n_stopped;
            r_out_floor   <= n_pos;
            r_out_motion  <= n_motion;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_status    = r_out_status;
    assign o_out_stopped   = r_out_stopped;
    assign o_out_car_floor = r_out_floor;
    assign o_out_motion    = r_out_motion;

`ifndef SYNTH
    // an idle car holds no calls
    a_idle_no_calls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_motion == MOT_IDLE) |-> ((r_up | r_down | r_car) == '0))
        else $error("idle car with pending calls");

    // a stop is only reported for a tick with an accepted status
    a_stop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_stopped) |-> (o_out_status == ST_OK))
        else $error("stop reported with error status");

    // input stalls only when both stages are full and the output is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // an advancing item lands in the result register
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced item missing from result register");
`endif

endmodule
